@@ rtl/teq_pkg.sv @@
package teq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // op codes
    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_POP      = 2'd1;
    localparam logic [1:0] OP_ADVANCE  = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_GIVEN    = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_ENDED    = 3'd4;
    localparam logic [2:0] ST_ADVANCED = 3'd5;

    typedef struct packed {
        logic [15:0] seq;
        logic [15:0] id;
        logic [31:0] time_val;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/teq_ram.sv @@
module teq_ram #(
    parameter int DATA_W = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/timed_event_queue_core.sv @@
// channel   | dir | tdata (low bit up)                         | tuser
// s_ (item) | in  | event_id 16, event_time 32, is_absolute 1   | op 2
// m_ (res)  | out | due_id 16, due_time 32, now_time 32         | status 3
// cfg_      | in  | run_duration 32 on cfg_wr_data             | -
//
// schedule, advance and refused items are answered straight from the idle state.
// a pop scans every stored entry through the single read port, one per cycle,
// then, if the earliest entry is due, shifts the later entries down one slot a cycle.
// aresetn is synchronous; entry storage is not cleared, only count, time, sequence and run duration.
// a new transaction is taken once the sequencer is idle and the result register is free.
module timed_event_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // event_id, event_time, is_absolute, zero fill
    input  logic [1:0]  s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // due_id, due_time, now_time
    output logic [2:0]  m_tuser   // status
);
    import teq_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT, S_DONE} state_t;

    state_t           state_reg;
    logic [31:0]      run_dur_reg;
    logic [31:0]      now_reg;
    logic [CNT_W-1:0] count_reg;
    logic [15:0]      seq_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_time_reg;
    logic [15:0]      best_id_reg;
    logic [2:0]       res_status_reg;

    logic             m_tvalid_reg;
    logic [2:0]       m_status_reg;
    logic [15:0]      m_id_reg;
    logic [31:0]      m_time_reg;
    logic [31:0]      m_now_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    logic [1:0]  in_op;
    logic [15:0] in_id;
    logic [31:0] in_time;
    logic        in_abs;
    logic        accept;
    logic        out_free;
    logic        ended;
    logic        pop_start;
    logic [32:0] rel_sum;
    logic [31:0] sched_time;
    logic        better;
    logic        scan_last;

    assign in_op   = s_tuser;
    assign in_id   = s_tdata[15:0];
    assign in_time = s_tdata[47:16];
    assign in_abs  = s_tdata[48];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign ended    = now_reg >= run_dur_reg;

    // a pop on a non-empty running queue goes to the scan
    assign pop_start = accept && (in_op == OP_POP) && !ended && (count_reg != '0);

    // saturating relative time
    assign rel_sum    = {1'b0, now_reg} + {1'b0, in_time};
    assign sched_time = in_abs ? in_time : (rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0]);

    // scan compare, strict so that the earlier slot wins a tie
    assign better    = !found_reg || (rd_data.time_val < best_time_reg);
    assign scan_last = ({1'b0, idx_reg} == count_reg - CNT_W'(1));

    // read address issued in the cycle before its data is used
    always_comb begin
        unique case (state_reg)
            S_SCAN:     rd_addr = idx_reg + IDX_W'(1);
            S_SHIFT_RD: rd_addr = idx_reg + IDX_W'(1);
            S_SHIFT:    rd_addr = idx_reg + IDX_W'(2);
            default:    rd_addr = '0;
        endcase
    end

    // write port: append on schedule, move down on shift
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data;
        if (state_reg == S_SHIFT) begin
            wr_en = 1'b1;
        end else if (accept && in_op == OP_SCHEDULE && !ended
                     && count_reg < CNT_W'(QUEUE_DEPTH)) begin
            wr_en            = 1'b1;
            wr_addr          = count_reg[IDX_W-1:0];
            wr_data.time_val = sched_time;
            wr_data.id       = in_id;
            wr_data.seq      = seq_reg;
        end
    end

    teq_ram #(
        .DATA_W (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_dur_reg <= '0;
        end else if (cfg_wr_en) begin
            run_dur_reg <= cfg_wr_data;
        end
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            now_reg      <= '0;
            count_reg    <= '0;
            seq_reg      <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        // a pop that scans delivers its result later
                        m_tvalid_reg <= !pop_start;
                        m_id_reg     <= '0;
                        m_time_reg   <= '0;
                        m_now_reg    <= now_reg;
                        if (in_op == OP_UNUSED) begin
                            m_status_reg <= ST_NONE;
                        end else if (ended) begin
                            m_status_reg <= ST_ENDED;
                        end else if (in_op == OP_SCHEDULE) begin
                            if (count_reg < CNT_W'(QUEUE_DEPTH)) begin
                                m_status_reg <= ST_ACCEPTED;
                                count_reg    <= count_reg + CNT_W'(1);
                                seq_reg      <= seq_reg + 16'd1;
                            end else begin
                                m_status_reg <= ST_FULL;
                            end
                        end else if (in_op == OP_ADVANCE) begin
                            m_status_reg <= ST_ADVANCED;
                            now_reg      <= now_reg + 32'd1;
                            m_now_reg    <= now_reg + 32'd1;
                        end else if (count_reg == '0) begin
                            m_status_reg <= ST_NONE;
                        end else begin
                            // pop: start the scan
                            idx_reg      <= '0;
                            found_reg    <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                    end else if (m_tvalid_reg && m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (better) begin
                        best_idx_reg  <= idx_reg;
                        best_time_reg <= rd_data.time_val;
                        best_id_reg   <= rd_data.id;
                    end
                    found_reg <= 1'b1;
                    idx_reg   <= idx_reg + IDX_W'(1);
                    if (scan_last) begin
                        if ((better ? rd_data.time_val : best_time_reg) > now_reg) begin
                            res_status_reg <= ST_NONE;
                            state_reg      <= S_DONE;
                        end else begin
                            res_status_reg <= ST_GIVEN;
                            idx_reg        <= better ? idx_reg : best_idx_reg;
                            state_reg      <= S_SHIFT_RD;
                        end
                    end
                end
                S_SHIFT_RD: begin
                    if ({1'b0, idx_reg} + CNT_W'(1) >= count_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if ({1'b0, idx_reg} + CNT_W'(2) >= count_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_id_reg     <= (res_status_reg == ST_GIVEN) ? best_id_reg : 16'd0;
                        m_time_reg   <= (res_status_reg == ST_GIVEN) ? best_time_reg : 32'd0;
                        m_now_reg    <= now_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_now_reg, m_time_reg, m_id_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == S_IDLE))
        else $error("ready while sequencer busy");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_status_reg == ST_GIVEN) |->
        $past(state_reg) == S_DONE || count_reg == $past(count_reg) - CNT_W'(1))
        else $error("given event did not shrink the queue");
`endif

endmodule
